FILE: sv/gwm_pkg.sv
package gwm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_END     = 2'd3
  } op_t;

  localparam logic [7:0] STAR_CODE  = 8'h2A;
  localparam logic [7:0] QMARK_CODE = 8'h3F;
  localparam logic [7:0] FOLD_DELTA = 8'h20;

  // one processing step handed from the input register to the datapath
  typedef struct packed {
    logic       go;
    op_t        op;
    logic [7:0] ch;
  } step_t;

  // ascii case folding, A-Z only
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) r = c + FOLD_DELTA;
    return r;
  endfunction

endpackage

FILE: sv/gwm_if.sv
interface gwm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_value;

  modport source (output valid, output operation, output char_value, input ready);
  modport sink   (input valid, input operation, input char_value, output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

FILE: sv/gwm_pattern_store.sv
module gwm_pattern_store #(
  parameter int DEPTH = 32,
  parameter int LEN_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  gwm_pkg::step_t       step,
  output logic [DEPTH-1:0]     star_mask,
  output logic [DEPTH-1:0]     hit_mask,
  output logic [DEPTH-1:0]     len_mask,
  output logic [LEN_W-1:0]     length,
  output logic                 overflow
);
  import gwm_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] pattern [DEPTH];
  logic       full;

  assign full = (length == LEN_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (step.go && step.op == OP_PATTERN && !full) begin
      pattern[length[IDX_W-1:0]] <= step.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (step.go) begin
      case (step.op)
        OP_CLEAR: begin
          length   <= '0;
          overflow <= 1'b0;
        end
        OP_PATTERN: begin
          if (full) overflow <= 1'b1;
          else      length   <= length + LEN_W'(1);
        end
        default: ;
      endcase
    end
  end

  // each entry compared in its own lane against the current text byte
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      star_mask[i] = (pattern[i] == STAR_CODE);
      hit_mask[i]  = (pattern[i] == step.ch) || (pattern[i] == QMARK_CODE);
      len_mask[i]  = (LEN_W'(i) < length);
    end
  end

endmodule

FILE: sv/gwm_active_set.sv
module gwm_active_set #(
  parameter int DEPTH = 32,
  parameter int LEN_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  gwm_pkg::step_t   step,
  input  logic [DEPTH-1:0] star_mask,
  input  logic [DEPTH-1:0] hit_mask,
  input  logic [DEPTH-1:0] len_mask,
  input  logic [LEN_W-1:0] length,
  output logic             verdict
);
  import gwm_pkg::*;

  localparam int LVL = $clog2(DEPTH + 1);
  localparam logic [DEPTH:0] REARM = {{DEPTH{1'b0}}, 1'b1};

  logic [DEPTH:0]   active;
  logic [DEPTH:0]   active_next;
  logic [DEPTH:0]   closed;
  logic [DEPTH-1:0] star_eff;
  logic [DEPTH:0]   gen  [LVL+1];
  logic [DEPTH:0]   prop [LVL+1];

  assign star_eff = star_mask & len_mask;

  // star closure as a log-depth prefix: position j inherits from j-1 across a star
  always_comb begin
    gen[0]  = active;
    prop[0] = {star_eff, 1'b0};
    for (int l = 0; l < LVL; l++) begin
      for (int j = 0; j <= DEPTH; j++) begin
        if (j >= (1 << l)) begin
          gen[l+1][j]  = gen[l][j] | (prop[l][j] & gen[l][j-(1<<l)]);
          prop[l+1][j] = prop[l][j] & prop[l][j-(1<<l)];
        end else begin
          gen[l+1][j]  = gen[l][j];
          prop[l+1][j] = prop[l][j];
        end
      end
    end
    closed = gen[LVL];
  end

  always_comb begin
    active_next = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (closed[i] && star_eff[i]) active_next[i] = 1'b1;
      if (closed[i] && len_mask[i] && !star_mask[i] && hit_mask[i]) active_next[i+1] = 1'b1;
    end
  end

  assign verdict = closed[length];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= REARM;
    end else if (step.go) begin
      case (step.op)
        OP_TEXT: active <= active_next;
        default: active <= REARM;
      endcase
    end
  end

endmodule

FILE: sv/glob_wildcard_match_unit.sv
// glob_wildcard_match_unit: case-insensitive glob matcher, '*' and '?' wildcards
// items channel: one beat per operation (clear pattern, pattern byte, text byte,
//   end of text) with a byte in char_value; bytes A-Z are folded to lower case
// results channel: one beat per end-of-text, carrying matched and
//   pattern_overflow; matched is forced low when pattern bytes were dropped
// a beat lands in the input register; once it goes on, the pattern store and the
//   active position set are updated and any verdict is written to the result
//   register, from which it is offered to the receiver
// throughput is one beat per cycle unless an end-of-text beat waits for the receiver;
//   the active set's star closure over all PATTERN_DEPTH+1 positions is combinational
// while the receiver stalls, pattern and text beats keep flowing; only an
//   end-of-text beat waits in the input register, holding ready low, until the
//   result register is taken
// reset (synchronous, active high) empties the pattern, clears the overflow flag
//   and arms position zero; the store contents are undefined until loaded
// after end-of-text the pattern is kept and the matcher re-arms for the next name
module glob_wildcard_match_unit #(
  parameter int PATTERN_DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  gwm_in_if.sink    items,
  gwm_out_if.source results
);
  import gwm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_DEPTH + 1);

  logic                     s1_valid;
  op_t                      s1_op;
  logic [7:0]               s1_ch;
  logic                     s1_go;
  step_t                    step;
  logic [PATTERN_DEPTH-1:0] star_mask;
  logic [PATTERN_DEPTH-1:0] hit_mask;
  logic [PATTERN_DEPTH-1:0] len_mask;
  logic [LEN_W-1:0]         length;
  logic                     overflow;
  logic                     verdict;
  logic                     out_valid;
  logic                     out_matched;
  logic                     out_overflow;

  assign s1_go       = s1_valid && (s1_op != OP_END || !out_valid || results.ready);
  assign items.ready = !s1_valid || s1_go;

  assign step.go = s1_go;
  assign step.op = s1_op;
  assign step.ch = s1_ch;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_op <= op_t'(items.operation);
      s1_ch <= fold(items.char_value);
    end
  end

  gwm_pattern_store #(.DEPTH(PATTERN_DEPTH), .LEN_W(LEN_W)) u_store (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .star_mask (star_mask),
    .hit_mask  (hit_mask),
    .len_mask  (len_mask),
    .length    (length),
    .overflow  (overflow)
  );

  gwm_active_set #(.DEPTH(PATTERN_DEPTH), .LEN_W(LEN_W)) u_active (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .star_mask (star_mask),
    .hit_mask  (hit_mask),
    .len_mask  (len_mask),
    .length    (length),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_op == OP_END) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_op == OP_END) begin
      out_matched  <= verdict && !overflow;
      out_overflow <= overflow;
    end
  end

  assign results.valid            = out_valid;
  assign results.matched          = out_matched;
  assign results.pattern_overflow = out_overflow;

`ifndef SYNTH
  a_match_no_overflow: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.matched |-> !results.pattern_overflow)
    else $error("match reported with pattern overflow");

  a_stall_only_on_end: assert property (@(posedge clk) disable iff (rst)
    !items.ready |-> s1_valid && s1_op == OP_END && results.valid && !results.ready)
    else $error("input stalled without a blocked end-of-text beat");

  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_op == OP_END |=> results.valid)
    else $error("end-of-text beat did not produce a result");

  a_no_result_from_other: assert property (@(posedge clk) disable iff (rst)
    !results.valid ##1 results.valid |-> $past(s1_go) && $past(s1_op) == OP_END)
    else $error("result appeared without an end-of-text beat");
`endif

endmodule
